FILE: rtl/hsv_to_rgb_pixel_defines.svh
// Assertion macros shared by the HSV to RGB pixel converter
`ifndef HSV_TO_RGB_PIXEL_DEFINES_SVH
`define HSV_TO_RGB_PIXEL_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define HSVRGB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hsvrgb check failed");

// Next-cycle implication, checked on every rising edge outside reset
`define HSVRGB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hsvrgb check failed");

`endif

FILE: rtl/hsvrgb_pkg.sv
// Shared constants, types and pipeline bundle for the HSV to RGB converter
package hsvrgb_pkg;

  localparam int HUE_BITS     = 16;
  localparam int CHANNEL_BITS = 8;

  localparam int HUE_W   = HUE_BITS + 1;
  localparam int PROD_W  = CHANNEL_BITS + HUE_BITS;
  localparam int NUM_W   = 2 * CHANNEL_BITS + HUE_BITS;
  localparam int QUO_W   = 2 * CHANNEL_BITS;
  localparam int LATENCY = 5;

  localparam logic [CHANNEL_BITS-1:0] CMAX      = '1;
  localparam logic [HUE_BITS:0]       HUE_ONE   = {1'b1, {HUE_BITS{1'b0}}};
  localparam logic [PROD_W-1:0]       DEN       = {CMAX, {HUE_BITS{1'b0}}};
  localparam logic [NUM_W-1:0]        DEN_HALF  =
    {{(CHANNEL_BITS + 1){1'b0}}, CMAX, {(HUE_BITS - 1){1'b0}}};
  localparam logic [QUO_W-1:0]        CMAX_HALF =
    {{(CHANNEL_BITS + 1){1'b0}}, CMAX[CHANNEL_BITS-1:1]};

  // floor(x / CMAX) via a truncated reciprocal; estimate is low by at most one
  localparam int RECIP_SH = QUO_W + CHANNEL_BITS + 1;
  localparam int RECIP_W  = RECIP_SH - CHANNEL_BITS + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << RECIP_SH) / ((64'd1 << CHANNEL_BITS) - 64'd1));

  typedef enum logic [2:0] {
    SEC_R_Y = 3'd0,
    SEC_Y_G = 3'd1,
    SEC_G_C = 3'd2,
    SEC_C_B = 3'd3,
    SEC_B_M = 3'd4,
    SEC_M_R = 3'd5
  } sector_e;

  typedef struct packed {
    logic                    vld;
    logic                    blk;
    sector_e                 sec;
    logic [HUE_BITS-1:0]     frac;
    logic [CHANNEL_BITS-1:0] sat;
    logic [CHANNEL_BITS-1:0] val;
    logic [CHANNEL_BITS-1:0] alpha;
  } pix_t;

endpackage

FILE: rtl/hsvrgb_sector.sv
// First stage: hue range check, hue times six into sector and fraction
module hsvrgb_sector import hsvrgb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic [HUE_W-1:0]        hue_i,
  input  logic [CHANNEL_BITS-1:0] saturation_i,
  input  logic [CHANNEL_BITS-1:0] brightness_i,
  input  logic [CHANNEL_BITS-1:0] alpha_in_i,
  output pix_t                    pix_o
);

  logic [HUE_BITS+2:0] h6;
  pix_t                pix_d;
  pix_t                pix_q;
  logic                vld_q;

  // A full turn has zero low bits, so it lands on sector zero by itself
  always_comb begin
    h6         = {1'b0, hue_i[HUE_BITS-1:0], 2'b00} + {2'b00, hue_i[HUE_BITS-1:0], 1'b0};
    pix_d.vld  = accept_i;
    pix_d.blk  = hue_i[HUE_BITS] & (|hue_i[HUE_BITS-1:0]);
    pix_d.sec  = sector_e'(h6[HUE_BITS+2:HUE_BITS]);
    pix_d.frac = h6[HUE_BITS-1:0];
    pix_d.sat  = saturation_i;
    pix_d.val  = brightness_i;
    pix_d.alpha = alpha_in_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= pix_d.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
  end

  always_comb begin
    pix_o     = pix_q;
    pix_o.vld = vld_q;
  end

endmodule

FILE: rtl/hsvrgb_div.sv
// Rescale back to channel range: floor(x / CMAX) via reciprocal and fixup
module hsvrgb_div import hsvrgb_pkg::*; (
  input  logic                    clk_i,
  input  logic [QUO_W-1:0]        x_i,
  output logic [CHANNEL_BITS-1:0] quot_o
);

  localparam int MUL_W = QUO_W + RECIP_W;

  logic [MUL_W-1:0]        prod;
  logic [CHANNEL_BITS-1:0] est_d;
  logic [CHANNEL_BITS-1:0] est_q;
  logic [QUO_W-1:0]        x_q;
  logic [QUO_W-1:0]        est_mul;
  logic [QUO_W-1:0]        rem;

  always_comb begin
    prod  = MUL_W'(x_i) * MUL_W'(RECIP);
    est_d = prod[RECIP_SH +: CHANNEL_BITS];
  end

  always_ff @(posedge clk_i) begin
    est_q <= est_d;
    x_q   <= x_i;
  end

  // est * CMAX is a shift and subtract; bump the estimate when a full CMAX is left
  always_comb begin
    est_mul = {est_q, {CHANNEL_BITS{1'b0}}} - QUO_W'(est_q);
    rem     = x_q - est_mul;
    quot_o  = est_q + CHANNEL_BITS'(rem >= QUO_W'(CMAX));
  end

endmodule

FILE: rtl/hsv_to_rgb_pixel.sv
// Top level: five-stage HSV to RGB pixel pipeline
//
//  Channel  | Ports                                             | Transfer
//  ---------+---------------------------------------------------+-------------------------
//  input    | start, busy, hue_i, saturation_i, brightness_i,   | start high, busy low
//           | alpha_in_i                                        |
//  result   | done_o, red_o, green_o, blue_o, alpha_out_o       | done_o high, one cycle
//
// One pixel enters per clock; busy stays low, so the input never waits.
// Each result reaches done_o through the registered chain hue*6, S*f,
// V*(1-S*f), reciprocal multiply, fixup and channel select.
// Reset clears only the valid bits; pixels in flight are dropped.
// The receiver takes every result, so no stage ever holds.
module hsv_to_rgb_pixel import hsvrgb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [HUE_W-1:0]        hue_i,
  input  logic [CHANNEL_BITS-1:0] saturation_i,
  input  logic [CHANNEL_BITS-1:0] brightness_i,
  input  logic [CHANNEL_BITS-1:0] alpha_in_i,
  output logic                    done_o,
  output logic [CHANNEL_BITS-1:0] red_o,
  output logic [CHANNEL_BITS-1:0] green_o,
  output logic [CHANNEL_BITS-1:0] blue_o,
  output logic [CHANNEL_BITS-1:0] alpha_out_o
);

`include "hsv_to_rgb_pixel_defines.svh"

  pix_t pix1;
  pix_t pix2_d, pix2_q;
  pix_t pix3_q, pix4_q;
  logic vld2_q, vld3_q, vld4_q, done_q;

  logic [PROD_W-1:0]       sf_d, sf_q, sfi_d, sfi_q;
  logic [PROD_W:0]         sfi_full;
  logic [HUE_BITS:0]       inv_frac;
  logic [QUO_W-1:0]        np;
  logic [QUO_W-1:0]        xp2_d, xp2_q, xp3_q;
  logic [NUM_W-1:0]        mq, mt;
  logic [QUO_W-1:0]        xq_d, xq_q, xt_d, xt_q;
  logic [CHANNEL_BITS-1:0] p4, q4, t4;
  logic [CHANNEL_BITS-1:0] red_d, green_d, blue_d;
  logic [CHANNEL_BITS-1:0] red_q, green_q, blue_q, alpha_q;

  logic                    hue_over;
  logic                    rgb_black;
  logic [CHANNEL_BITS-1:0] rg_max, rgb_max;

  assign busy = 1'b0;

  hsvrgb_sector u_sector (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (start & ~busy),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .alpha_in_i   (alpha_in_i),
    .pix_o        (pix1)
  );

  // Stage 2: S*f, S*(1-f) and the rounded numerator of P
  always_comb begin
    pix2_d   = pix1;
    inv_frac = HUE_ONE - {1'b0, pix1.frac};
    sf_d     = PROD_W'(pix1.sat) * PROD_W'(pix1.frac);
    sfi_full = (PROD_W + 1)'(pix1.sat) * (PROD_W + 1)'(inv_frac);
    sfi_d    = sfi_full[PROD_W-1:0];
    np       = {{CHANNEL_BITS{1'b0}}, pix1.val} * {{CHANNEL_BITS{1'b0}}, CMAX - pix1.sat};
    xp2_d    = np + CMAX_HALF;
  end

  // Stage 3: V*(den - S*f) and V*(den - S*(1-f)), each plus half of den, drop the hue fraction bits
  always_comb begin
    mq   = NUM_W'(pix2_q.val) * NUM_W'(DEN - sf_q) + DEN_HALF;
    mt   = NUM_W'(pix2_q.val) * NUM_W'(DEN - sfi_q) + DEN_HALF;
    xq_d = mq[NUM_W-1:HUE_BITS];
    xt_d = mt[NUM_W-1:HUE_BITS];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld2_q <= pix1.vld;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
      done_q <= vld4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pix2_q  <= pix2_d;
    sf_q    <= sf_d;
    sfi_q   <= sfi_d;
    xp2_q   <= xp2_d;
    pix3_q  <= pix2_q;
    xq_q    <= xq_d;
    xt_q    <= xt_d;
    xp3_q   <= xp2_q;
    pix4_q  <= pix3_q;
    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
    alpha_q <= pix4_q.alpha;
  end

  // Stage 4: rescale P, Q and T to the channel range
  hsvrgb_div u_div_p (.clk_i(clk_i), .x_i(xp3_q), .quot_o(p4));
  hsvrgb_div u_div_q (.clk_i(clk_i), .x_i(xq_q),  .quot_o(q4));
  hsvrgb_div u_div_t (.clk_i(clk_i), .x_i(xt_q),  .quot_o(t4));

  // Stage 5: channel order by sector; out-of-range hue gives black
  always_comb begin
    unique case (pix4_q.sec)
      SEC_R_Y: begin red_d = pix4_q.val; green_d = t4;         blue_d = p4;         end
      SEC_Y_G: begin red_d = q4;         green_d = pix4_q.val; blue_d = p4;         end
      SEC_G_C: begin red_d = p4;         green_d = pix4_q.val; blue_d = t4;         end
      SEC_C_B: begin red_d = p4;         green_d = q4;         blue_d = pix4_q.val; end
      SEC_B_M: begin red_d = t4;         green_d = p4;         blue_d = pix4_q.val; end
      default: begin red_d = pix4_q.val; green_d = p4;         blue_d = q4;         end
    endcase
    if (pix4_q.blk) begin
      red_d   = '0;
      green_d = '0;
      blue_d  = '0;
    end
  end

  assign done_o      = done_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign alpha_out_o = alpha_q;

  assign hue_over  = hue_i[HUE_BITS] & (|hue_i[HUE_BITS-1:0]);
  assign rgb_black = (red_o == '0) && (green_o == '0) && (blue_o == '0);
  assign rg_max    = (red_o > green_o) ? red_o : green_o;
  assign rgb_max   = (rg_max > blue_o) ? rg_max : blue_o;

  `HSVRGB_ASSERT_IMPL(a_done_has_start, done_o, $past(start & ~busy, LATENCY))
  `HSVRGB_ASSERT_IMPL(a_alpha_kept, done_o, alpha_out_o == $past(alpha_in_i, LATENCY))
  `HSVRGB_ASSERT_IMPL(a_black_hue, done_o && $past(hue_over, LATENCY), rgb_black)
  `HSVRGB_ASSERT_IMPL(a_max_is_value, done_o, rgb_black || rgb_max == $past(brightness_i, LATENCY))
  `HSVRGB_ASSERT_NEXT(a_no_stall, start, !busy)

endmodule
